[sv/fkhd_pkg.sv]
// Shared types and constants for the four-key holdoff debouncer.
package fkhd_pkg;

  localparam int unsigned NumKeys = 4;
  localparam int unsigned KeyW = 2;
  localparam int unsigned HoldW = 2;
  localparam int unsigned FuncW = 2;
  localparam int unsigned BlW = 8;
  localparam int unsigned SlotW = NumKeys + 1;
  localparam int unsigned BlMax = 255;
  localparam int unsigned RampReset = 100;

  localparam logic [HoldW-1:0] HOLD_TICKS_RESET = 2'd3;

  localparam logic [FuncW-1:0] FUNC_PIN = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FAST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SLOW = 2'd2;

  localparam int unsigned KEY_DOWN = 1;
  localparam int unsigned KEY_LEFT = 2;
  localparam int unsigned KEY_RIGHT = 3;

  typedef enum logic [1:0] {
    RAMP_NONE = 2'd0,
    RAMP_DIM = 2'd1,
    RAMP_BRIGHT = 2'd2,
    RAMP_BRIGHT_ALT = 2'd3
  } ramp_mode_e;

  localparam logic REG_HOLDOFF_TICKS = 1'b0;

endpackage

[sv/four_key_holdoff_debouncer.sv]
// Top level of the four-key holdoff debouncer with its backlight ramp.
// An accepted item is registered in the input register, then all its results
// are formed in one pass into the result register, from which the results leave
// one per cycle while m_tready_i is high (up to five).
// An item waits in the input register only while the previous item's results
// drain; items without results pass at one per cycle.
// Reset clears all key state, stops the ramp, sets the ramp to 100 and the
// holdoff to three slow ticks.
module four_key_holdoff_debouncer
  import fkhd_pkg::*;
#(
  parameter int unsigned RAMP_SCALE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // key_index [1:0], level [2], zeros above.
  input  logic [1:0]  s_tuser_i,   // func [1:0].
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // event_key [1:0], released [2], backlight [10:3].
  output logic        m_tuser_o,   // kind [0].
  output logic        m_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RampMax = 255 * RAMP_SCALE;
  localparam int unsigned RvW = $clog2(RampMax + 1);
  localparam longint unsigned SqMax = longint'(RampMax) * longint'(RampMax);
  localparam int unsigned SqW = $clog2(SqMax + 1);
  localparam longint unsigned BlDiv = 255 * RAMP_SCALE * RAMP_SCALE;
  localparam int unsigned DivL = $clog2(BlDiv);
  localparam int unsigned Shift = SqW + DivL;
  localparam longint unsigned Recip = ((64'd1 << Shift) + BlDiv - 64'd1) / BlDiv;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW = (SqW + RecipW > Shift + BlW) ? SqW + RecipW : Shift + BlW;

  localparam logic [RvW-1:0] RV_MAX = RvW'(RampMax);
  localparam logic [RvW-1:0] RV_RESET = RvW'(RampReset);
  localparam logic [SqW-1:0] SQ_RESET = SqW'(RampReset * RampReset);
  localparam logic [RecipW-1:0] RECIP = RecipW'(Recip);

  logic                 in_vld_q;
  logic [FuncW-1:0]     in_func_q;
  logic [KeyW-1:0]      in_key_q;
  logic                 in_level_q;

  logic [HoldW-1:0]     ticks_q;
  logic [NumKeys-1:0]   live_q, live_d;
  logic [NumKeys-1:0]   rep_q, rep_d;
  logic [NumKeys-1:0]   marks_q, marks_d;
  logic [HoldW-1:0]     hold_q [NumKeys];
  logic [HoldW-1:0]     hold_d [NumKeys];
  ramp_mode_e           mode_q, mode_d;
  logic [RvW-1:0]       rv_q, rv_d;
  logic [SqW-1:0]       sq_q, sq_d;

  logic [SlotW-1:0]     buf_mask_q, buf_mask_d;
  logic [NumKeys-1:0]   buf_rel_q;
  logic [BlW-1:0]       buf_bl_q;

  logic [SlotW-1:0]     slots;
  logic [NumKeys-1:0]   rpt;
  logic [ProdW-1:0]     prod;
  logic [BlW-1:0]       bl_new;
  logic [SlotW-1:0]     low_bit;
  logic                 buf_free;
  logic                 advance;
  logic                 s_hs;
  logic                 m_hs;
  logic                 cfg_wr;

  logic [KeyW-1:0]      out_key;
  logic                 out_rel;
  logic [BlW-1:0]       out_bl;

  assign pready = 1'b1;
  assign prdata = {{(32 - HoldW){1'b0}}, ticks_q};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOLDOFF_TICKS);

  assign low_bit    = buf_mask_q & (~buf_mask_q + SlotW'(1));
  assign m_tvalid_o = |buf_mask_q;
  assign m_tlast_o  = m_tvalid_o && ((buf_mask_q & ~low_bit) == '0);
  assign m_hs       = m_tvalid_o && m_tready_i;
  assign buf_free   = (buf_mask_q == '0) || (m_tready_i && m_tlast_o);
  assign advance    = in_vld_q && buf_free;
  assign s_tready_o = !in_vld_q || advance;
  assign s_hs       = s_tvalid_i && s_tready_o;

  always_comb begin
    live_d  = live_q;
    rep_d   = rep_q;
    marks_d = marks_q;
    hold_d  = hold_q;
    mode_d  = mode_q;
    rv_d    = rv_q;
    sq_d    = sq_q;
    slots   = '0;
    rpt     = '0;
    case (in_func_q)
      FUNC_PIN: begin
        live_d[in_key_q]  = in_level_q;
        marks_d[in_key_q] = 1'b1;
      end
      FUNC_FAST: begin
        marks_d = '0;
        for (int i = 0; i < NumKeys; i++) begin
          if (marks_q[i] && (hold_q[i] == '0)) begin
            rpt[i]    = 1'b1;
            hold_d[i] = ticks_q;
          end
        end
      end
      FUNC_SLOW: begin
        case (mode_q)
          RAMP_NONE: begin
          end
          RAMP_DIM: begin
            slots[0] = 1'b1;
            if (rv_q != '0) begin
              rv_d = rv_q - RvW'(1);
              sq_d = sq_q - SqW'({rv_q, 1'b0}) + SqW'(1);
            end
          end
          default: begin
            slots[0] = 1'b1;
            if (rv_q < RV_MAX) begin
              rv_d = rv_q + RvW'(1);
              sq_d = sq_q + SqW'({rv_q, 1'b0}) + SqW'(1);
            end
          end
        endcase
        for (int i = 0; i < NumKeys; i++) begin
          if (hold_q[i] != '0) begin
            hold_d[i] = hold_q[i] - HoldW'(1);
            if (hold_q[i] == HoldW'(1)) begin
              rpt[i] = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NumKeys; i++) begin
      if (rpt[i] && (live_q[i] != rep_q[i])) begin
        rep_d[i] = ~rep_q[i];
        if (((i == KEY_LEFT) || (i == KEY_RIGHT)) && live_q[KEY_DOWN]) begin
          if (!live_q[i]) begin
            mode_d = RAMP_NONE;
          end else if (i == KEY_LEFT) begin
            mode_d = RAMP_DIM;
          end else begin
            mode_d = RAMP_BRIGHT;
          end
        end else begin
          slots[i + 1] = 1'b1;
        end
      end
    end
  end

  // The backlight is the square divided by a constant, done as a multiply
  // by a rounded-up reciprocal that is exact over the whole square range.
  assign prod   = ProdW'(sq_d) * ProdW'(RECIP);
  assign bl_new = prod[Shift +: BlW];

  always_comb begin
    buf_mask_d = buf_mask_q;
    if (advance) begin
      buf_mask_d = slots;
    end else if (m_hs) begin
      buf_mask_d = buf_mask_q & ~low_bit;
    end
  end

  always_comb begin
    out_key = '0;
    out_rel = 1'b0;
    out_bl  = '0;
    if (buf_mask_q[0]) begin
      out_bl = buf_bl_q;
    end else begin
      for (int i = NumKeys - 1; i >= 0; i--) begin
        if (buf_mask_q[i + 1]) begin
          out_key = KeyW'(i);
          out_rel = buf_rel_q[i];
        end
      end
    end
  end

  assign m_tuser_o = buf_mask_q[0];
  assign m_tdata_o = {{(16 - BlW - KeyW - 1){1'b0}}, out_bl, out_rel, out_key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      ticks_q    <= HOLD_TICKS_RESET;
      live_q     <= '0;
      rep_q      <= '0;
      marks_q    <= '0;
      mode_q     <= RAMP_NONE;
      rv_q       <= RV_RESET;
      sq_q       <= SQ_RESET;
      buf_mask_q <= '0;
      for (int i = 0; i < NumKeys; i++) begin
        hold_q[i] <= '0;
      end
    end else begin
      in_vld_q   <= s_hs || (in_vld_q && !advance);
      buf_mask_q <= buf_mask_d;
      if (cfg_wr) begin
        ticks_q <= pwdata[HoldW-1:0];
      end
      if (advance) begin
        live_q  <= live_d;
        rep_q   <= rep_d;
        marks_q <= marks_d;
        hold_q  <= hold_d;
        mode_q  <= mode_d;
        rv_q    <= rv_d;
        sq_q    <= sq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_func_q  <= s_tuser_i;
      in_key_q   <= s_tdata_i[KeyW-1:0];
      in_level_q <= s_tdata_i[KeyW];
    end
    if (advance) begin
      buf_rel_q <= ~live_q;
      buf_bl_q  <= bl_new;
    end
  end

  a_ramp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q <= RV_MAX)
    else $error("Ramp value left its range.");

  a_square_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q == SqW'(SqW'(rv_q) * SqW'(rv_q)))
    else $error("Tracked square does not match the ramp value.");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_func_q) && $stable(in_key_q))
    else $error("Waiting item was lost or changed.");

endmodule
